@@ rtl/core/fqr_pkg.sv @@
// Shared constants for the FIFO queue with remove-by-id core.
// Holds parameter defaults, operation codes and status codes.
// No dependencies.
package fqr_pkg;

  localparam int DEPTH_DEF       = 32;
  localparam int HANDLE_BITS_DEF = 16;
  localparam int ID_BITS_DEF     = 16;

  localparam int OP_BITS     = 2;
  localparam int STATUS_BITS = 2;

  localparam logic [OP_BITS-1:0] OP_PUSH   = 2'd0;
  localparam logic [OP_BITS-1:0] OP_POP    = 2'd1;
  localparam logic [OP_BITS-1:0] OP_REMOVE = 2'd2;
  localparam logic [OP_BITS-1:0] OP_FIND   = 2'd3;

  localparam logic [STATUS_BITS-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL = 2'd2;

endpackage

@@ rtl/core/fqr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Used for the handle, id and link stores. No dependencies.
module fqr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/fifo_queue_with_remove_by_id_core.sv @@
// Top level of the FIFO queue with remove-by-id: sequencer, slot bitmap and pointers.
// Depends on fqr_pkg (codes, defaults) and fqr_ram (handle, id and link stores).
//
//   channel   signals                              handshake
//   command   start, busy, op, handle_in, id_in    taken when start && !busy
//   result    done, handle_out, status, occupancy  done high one cycle, no stall
//
// Push scans the slot bitmap one slot per cycle.
// Pop does one registered read of the head entry.
// Remove and find walk the linked entries, one RAM read per cycle through the
// shared id compare.
// Full push and empty pop answer in the cycle after start.
// Reset empties the queue at once; the entry stores need no clearing.
module fifo_queue_with_remove_by_id_core #(
  parameter int DEPTH       = fqr_pkg::DEPTH_DEF,
  parameter int HANDLE_BITS = fqr_pkg::HANDLE_BITS_DEF,
  parameter int ID_BITS     = fqr_pkg::ID_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [fqr_pkg::OP_BITS-1:0]      op,
  input  logic [HANDLE_BITS-1:0]           handle_in,
  input  logic [ID_BITS-1:0]               id_in,
  output logic                             done,
  output logic [HANDLE_BITS-1:0]           handle_out,
  output logic [fqr_pkg::STATUS_BITS-1:0]  status,
  output logic [$clog2(DEPTH+1)-1:0]       occupancy
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;
  localparam logic [1:0] S_WALK = 2'd3;

  logic [1:0]                    state;
  logic [fqr_pkg::OP_BITS-1:0]   op_r;
  logic [HANDLE_BITS-1:0]        handle_r;
  logic [ID_BITS-1:0]            id_r;
  logic [DEPTH-1:0]              slot_used;
  logic [AW-1:0]                 head;
  logic [AW-1:0]                 tail;
  logic [CW-1:0]                 count;
  logic [AW-1:0]                 idx;
  logic [AW-1:0]                 cur;
  logic [AW-1:0]                 prev;
  logic                          have_prev;
  logic [CW-1:0]                 n;

  logic [HANDLE_BITS-1:0]        rd_handle;
  logic [ID_BITS-1:0]            rd_id;
  logic [AW-1:0]                 rd_link;
  logic [AW-1:0]                 raddr;

  logic                          accept;
  logic                          scan_hit;
  logic                          walk_end;
  logic                          walk_hit;
  logic                          link_we;
  logic [AW-1:0]                 link_waddr;
  logic [AW-1:0]                 link_wdata;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign scan_hit = (state == S_SCAN) && !slot_used[idx];
  assign walk_end = (state == S_WALK) && (n == count);
  assign walk_hit = (state == S_WALK) && (n != count) && (rd_id == id_r);

  // While walking, chase the link just read; otherwise keep the head entry ready.
  assign raddr = (state == S_WALK) ? rd_link : head;

  always_comb begin
    link_we    = 1'b0;
    link_waddr = tail;
    link_wdata = idx;
    if (scan_hit && count != '0) begin
      link_we = 1'b1;
    end else if (walk_hit && op_r == fqr_pkg::OP_REMOVE && have_prev) begin
      link_we    = 1'b1;
      link_waddr = prev;
      link_wdata = rd_link;
    end
  end

  fqr_ram #(.WIDTH(HANDLE_BITS), .DEPTH(DEPTH)) u_handle_ram (
    .clk   (clk),
    .we    (scan_hit),
    .waddr (idx),
    .wdata (handle_r),
    .raddr (raddr),
    .rdata (rd_handle)
  );

  fqr_ram #(.WIDTH(ID_BITS), .DEPTH(DEPTH)) u_id_ram (
    .clk   (clk),
    .we    (scan_hit),
    .waddr (idx),
    .wdata (id_r),
    .raddr (raddr),
    .rdata (rd_id)
  );

  fqr_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (raddr),
    .rdata (rd_link)
  );

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= op;
      handle_r  <= handle_in;
      id_r      <= id_in;
      cur       <= head;
      have_prev <= 1'b0;
      n         <= '0;
      idx       <= '0;
    end else if (state == S_SCAN) begin
      idx <= idx + AW'(1);
    end else if (state == S_WALK) begin
      prev      <= cur;
      have_prev <= 1'b1;
      cur       <= rd_link;
      n         <= n + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      slot_used <= '0;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            handle_out <= '0;
            occupancy  <= count;
            unique case (op)
              fqr_pkg::OP_PUSH: begin
                if (count == CW'(DEPTH)) begin
                  status <= fqr_pkg::ST_FULL;
                  done   <= 1'b1;
                end else begin
                  state <= S_SCAN;
                end
              end
              fqr_pkg::OP_POP: begin
                if (count == '0) begin
                  status <= fqr_pkg::ST_MISS;
                  done   <= 1'b1;
                end else begin
                  state <= S_POP;
                end
              end
              default: begin
                state <= S_WALK;
              end
            endcase
          end
        end
        S_SCAN: begin
          // Take the lowest free slot; advance until one is found.
          if (scan_hit) begin
            slot_used[idx] <= 1'b1;
            if (count == '0) begin
              head <= idx;
            end
            tail       <= idx;
            count      <= count + CW'(1);
            handle_out <= '0;
            status     <= fqr_pkg::ST_OK;
            occupancy  <= count + CW'(1);
            done       <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_POP: begin
          slot_used[head] <= 1'b0;
          count           <= count - CW'(1);
          if (count == CW'(1)) begin
            head <= '0;
            tail <= '0;
          end else begin
            head <= rd_link;
          end
          handle_out <= rd_handle;
          status     <= fqr_pkg::ST_OK;
          occupancy  <= count - CW'(1);
          done       <= 1'b1;
          state      <= S_IDLE;
        end
        S_WALK: begin
          if (walk_end) begin
            handle_out <= '0;
            status     <= fqr_pkg::ST_MISS;
            occupancy  <= count;
            done       <= 1'b1;
            state      <= S_IDLE;
          end else if (walk_hit) begin
            status <= fqr_pkg::ST_OK;
            done   <= 1'b1;
            state  <= S_IDLE;
            if (op_r == fqr_pkg::OP_REMOVE) begin
              // Unlink the matching entry and release its slot.
              slot_used[cur] <= 1'b0;
              count          <= count - CW'(1);
              handle_out     <= rd_handle;
              occupancy      <= count - CW'(1);
              if (count == CW'(1)) begin
                head <= '0;
                tail <= '0;
              end else begin
                if (!have_prev) begin
                  head <= rd_link;
                end
                if (have_prev && cur == tail) begin
                  tail <= prev;
                end
              end
            end else begin
              handle_out <= '0;
              occupancy  <= count;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_bitmap_matches_count: assert property (@(posedge clk) disable iff (rst)
    $countones(slot_used) == int'(count))
    else $error("slot bitmap population differs from entry count");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_done_when_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while a transaction is still in progress");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    accept && !(op == fqr_pkg::OP_PUSH && count == CW'(DEPTH))
           && !(op == fqr_pkg::OP_POP && count == '0) |=> busy)
    else $error("accepted transaction did not start work");

  a_full_only_at_depth: assert property (@(posedge clk) disable iff (rst)
    done && status == fqr_pkg::ST_FULL |-> occupancy == CW'(DEPTH))
    else $error("full status reported below depth");

endmodule

@@ dv/tb_fifo_queue_with_remove_by_id_core.sv @@
// Self-checking testbench for fifo_queue_with_remove_by_id_core: directed and random
// push, pop, remove-by-id and find transactions, checked against a queue-level model.
// Depends on fqr_pkg and the core RTL.
module tb_fifo_queue_with_remove_by_id_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = fqr_pkg::DEPTH_DEF;
  localparam int HB           = fqr_pkg::HANDLE_BITS_DEF;
  localparam int IB           = fqr_pkg::ID_BITS_DEF;
  localparam int SB           = fqr_pkg::STATUS_BITS;
  localparam int OCC_BITS     = $clog2(DEPTH + 1);
  localparam int RANDOM_ITEMS = 1200;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int REPORT_LIMIT = 10;

  typedef logic [fqr_pkg::OP_BITS-1:0] op_t;

  typedef struct {
    logic [HB-1:0] handle;
    logic [IB-1:0] id;
  } thread_entry_t;

  typedef struct {
    logic [HB-1:0]       handle;
    logic [SB-1:0]       status;
    logic [OCC_BITS-1:0] occupancy;
  } queue_result_t;

  class ready_queue_scoreboard;
    thread_entry_t ready_threads[$];
    queue_result_t expected_results[$];
    int mismatches;
    int checked;
    int n_push, n_full, n_pop, n_empty_pop, n_remove, n_removed, n_find, n_found;
    int peak_occ;

    // Apply one accepted transaction to the queue and store the answer it must give.
    function void note_command(op_t cmd_op, logic [HB-1:0] cmd_handle,
                               logic [IB-1:0] cmd_id);
      queue_result_t r;
      thread_entry_t ent;
      int idx;
      r.handle = '0;
      r.status = fqr_pkg::ST_MISS;
      case (cmd_op)
        fqr_pkg::OP_PUSH: begin
          n_push++;
          if (ready_threads.size() >= DEPTH) begin
            r.status = fqr_pkg::ST_FULL;
            n_full++;
          end else begin
            ent.handle = cmd_handle;
            ent.id = cmd_id;
            ready_threads.push_back(ent);
            r.status = fqr_pkg::ST_OK;
          end
        end
        fqr_pkg::OP_POP: begin
          n_pop++;
          if (ready_threads.size() > 0) begin
            ent = ready_threads.pop_front();
            r.handle = ent.handle;
            r.status = fqr_pkg::ST_OK;
          end else begin
            n_empty_pop++;
          end
        end
        default: begin
          if (cmd_op == fqr_pkg::OP_REMOVE) n_remove++;
          else n_find++;
          // first match counted from the head wins
          for (idx = 0; idx < ready_threads.size(); idx++) begin
            if (ready_threads[idx].id == cmd_id) begin
              r.status = fqr_pkg::ST_OK;
              if (cmd_op == fqr_pkg::OP_REMOVE) begin
                r.handle = ready_threads[idx].handle;
                ready_threads.delete(idx);
                n_removed++;
              end else begin
                n_found++;
              end
              break;
            end
          end
        end
      endcase
      r.occupancy = OCC_BITS'(ready_threads.size());
      if (ready_threads.size() > peak_occ) peak_occ = ready_threads.size();
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [HB-1:0] got_handle, logic [SB-1:0] got_status,
                               logic [OCC_BITS-1:0] got_occ);
      queue_result_t exp_r;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: unexpected result handle=%h status=%0d occupancy=%0d",
                   $realtime, got_handle, got_status, got_occ);
        return;
      end
      exp_r = expected_results.pop_front();
      checked++;
      if (got_handle !== exp_r.handle || got_status !== exp_r.status ||
          got_occ !== exp_r.occupancy) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: result %0d wrong: handle %h/%h status %0d/%0d %s %0d/%0d (exp/got)",
                   $realtime, checked, exp_r.handle, got_handle, exp_r.status, got_status,
                   "occupancy", exp_r.occupancy, got_occ);
      end
    endfunction

    function void check_drained();
      if (expected_results.size() != 0) begin
        mismatches += expected_results.size();
        $display("%0d expected results never arrived", expected_results.size());
      end
    endfunction

    function int outstanding();
      return expected_results.size();
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic [fqr_pkg::OP_BITS-1:0] op;
  logic [HB-1:0]           handle_in;
  logic [IB-1:0]           id_in;
  logic                    done;
  logic [HB-1:0]           handle_out;
  logic [SB-1:0]           status;
  logic [OCC_BITS-1:0]     occupancy;

  ready_queue_scoreboard sb;
  bit quiet;
  int cycle_count;

  fifo_queue_with_remove_by_id_core #(
    .DEPTH(DEPTH),
    .HANDLE_BITS(HB),
    .ID_BITS(IB)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .op(op),
    .handle_in(handle_in),
    .id_in(id_in),
    .done(done),
    .handle_out(handle_out),
    .status(status),
    .occupancy(occupancy)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timed out after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // done is a one-cycle strobe with no back-pressure
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(handle_out, status, occupancy);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic op_t pick_op(int mode);
    int r;
    int p_push, p_pop, p_rem;
    r = $urandom_range(0, 99);
    case (mode)
      0:       begin p_push = 70; p_pop = 80; p_rem = 90; end  // fill toward full
      1:       begin p_push = 20; p_pop = 55; p_rem = 85; end  // drain
      2:       begin p_push = 35; p_pop = 60; p_rem = 80; end
      default: begin p_push = 25; p_pop = 35; p_rem = 70; end  // search heavy
    endcase
    if (r < p_push) return fqr_pkg::OP_PUSH;
    if (r < p_pop) return fqr_pkg::OP_POP;
    if (r < p_rem) return fqr_pkg::OP_REMOVE;
    return fqr_pkg::OP_FIND;
  endfunction

  // Small id pools at both ends of the range so searches hit; the rest spans all bits.
  function automatic logic [IB-1:0] pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return IB'($urandom_range(0, 7));
    if (r < 70) return {{(IB-3){1'b1}}, 3'($urandom_range(0, 7))};
    return IB'($urandom_range(0, (1 << IB) - 1));
  endfunction

  function automatic logic [HB-1:0] pick_handle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return HB'($urandom_range(0, (1 << HB) - 1));
  endfunction

  // Entered at a falling edge; holds the transaction until it is taken.
  task automatic send_command(op_t cmd_op, logic [HB-1:0] cmd_handle, logic [IB-1:0] cmd_id);
    start <= 1'b1;
    op <= cmd_op;
    handle_in <= cmd_handle;
    id_in <= cmd_id;
    do @(posedge clk); while (busy);
    sb.note_command(cmd_op, cmd_handle, cmd_id);
    @(negedge clk);
  endtask

  task automatic run_command(op_t cmd_op, logic [HB-1:0] cmd_handle, logic [IB-1:0] cmd_id);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    send_command(cmd_op, cmd_handle, cmd_id);
  endtask

  initial begin
    int mode;
    int len;
    int k;
    int random_sent;
    rst = 1'b1;
    start = 1'b0;
    op = fqr_pkg::OP_PUSH;
    handle_in = '0;
    id_in = '0;
    cycle_count = 0;
    quiet = 1'b0;
    random_sent = 0;
    sb = new();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty queue cases
    run_command(fqr_pkg::OP_POP, 16'h1111, 16'h0001);
    run_command(fqr_pkg::OP_REMOVE, 16'h2222, 16'h0000);
    run_command(fqr_pkg::OP_FIND, 16'h3333, 16'hFFFF);
    // field extremes and a duplicate id
    run_command(fqr_pkg::OP_PUSH, 16'h0000, 16'h0000);
    run_command(fqr_pkg::OP_PUSH, 16'hFFFF, 16'hFFFF);
    run_command(fqr_pkg::OP_PUSH, 16'h1234, 16'h0000);
    run_command(fqr_pkg::OP_PUSH, 16'h0005, 16'h0007);
    run_command(fqr_pkg::OP_FIND, 16'hABCD, 16'h0000);
    run_command(fqr_pkg::OP_FIND, 16'h0000, 16'h0009);
    // remove head (first of two matches), then tail
    run_command(fqr_pkg::OP_REMOVE, 16'h0000, 16'h0000);
    run_command(fqr_pkg::OP_REMOVE, 16'h0000, 16'h0007);
    run_command(fqr_pkg::OP_REMOVE, 16'h0000, 16'h5555);
    run_command(fqr_pkg::OP_PUSH, 16'h0006, 16'h0008);
    // remove from the middle, then the new tail
    run_command(fqr_pkg::OP_REMOVE, 16'hFFFF, 16'h0000);
    run_command(fqr_pkg::OP_REMOVE, 16'h0000, 16'h0008);
    run_command(fqr_pkg::OP_FIND, 16'h0000, 16'hFFFF);
    run_command(fqr_pkg::OP_POP, 16'h0000, 16'h0000);
    run_command(fqr_pkg::OP_POP, 16'hFFFF, 16'hFFFF);
    run_command(fqr_pkg::OP_PUSH, 16'h00A5, 16'h8000);
    run_command(fqr_pkg::OP_REMOVE, 16'h0000, 16'h8000);
    run_command(fqr_pkg::OP_FIND, 16'h0000, 16'h8000);

    while (random_sent < RANDOM_ITEMS) begin
      mode = $urandom_range(0, 3);
      quiet = ($urandom_range(0, 3) == 0);
      len = $urandom_range(20, 80);
      for (k = 0; k < len && random_sent < RANDOM_ITEMS; k++) begin
        run_command(pick_op(mode), pick_handle(), pick_id());
        random_sent++;
      end
    end
    start <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    sb.check_drained();

    $display("covered %0d transactions: %0d push (%0d refused full), %0d pop (%0d on empty)",
             sb.n_push + sb.n_pop + sb.n_remove + sb.n_find, sb.n_push, sb.n_full,
             sb.n_pop, sb.n_empty_pop);
    $display("%0d remove (%0d hit), %0d find (%0d hit), peak occupancy %0d, %0d results checked",
             sb.n_remove, sb.n_removed, sb.n_find, sb.n_found, sb.peak_occ, sb.checked);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
